@@ src/assert_macros.svh @@
// Concurrent assertion helpers used by the engine RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, idle while reset is high
`define SSRP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included
`define SSRP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/ssrp_pkg.sv @@
`timescale 1ns / 1ps
package ssrp_pkg;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  localparam logic [3:0] CODE_RESET_ON  = 4'h9;
  localparam logic [3:0] CODE_RESET_OFF = 4'h8;
  localparam logic [3:0] CODE_DATA_SET  = 4'hD;
  localparam logic [3:0] CODE_DATA_CLR  = 4'hC;
  localparam logic [3:0] CODE_CLK_HIGH  = 4'hF;
  localparam logic [3:0] CODE_CLK_LOW   = 4'hE;

  localparam logic [8:0] CMD_STATUS   = 9'h0FE;
  localparam logic [8:0] CMD_BANK_ONE = 9'h082;
  localparam logic [8:0] CMD_BANK_TWO = 9'h086;

  localparam logic [7:0] STATUS_HIGH_BYTE = 8'hFF;

  localparam logic [4:0] POS_DECODE = 5'd8;
  localparam logic [4:0] POS_CMD_END = 5'd9;
  localparam logic [4:0] POS_REPLY_END = 5'd16;
  localparam logic [4:0] POS_LAST = 5'd31;

  localparam logic CFG_BANK_ONE = 1'b0;
  localparam logic CFG_BANK_TWO = 1'b1;

  localparam logic [7:0] BANK_ONE_RESET = 8'd155;
  localparam logic [7:0] BANK_TWO_RESET = 8'd240;

  typedef struct packed {
    logic       func;
    logic [3:0] code;
    logic [7:0] status;
  } item_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } flow_t;

endpackage

@@ src/ssrp_in_stage.sv @@
`timescale 1ns / 1ps
module ssrp_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  ssrp_pkg::item_t in_item,
  input  logic           advance,
  output ssrp_pkg::flow_t flow,
  output ssrp_pkg::item_t item
);
  import ssrp_pkg::*;

  logic full;
  logic take;

  assign in_stall = full && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (take) begin
      full <= 1'b1;
    end else if (advance) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= in_item;
    end
  end

  assign flow.valid   = full;
  assign flow.advance = full && advance;

endmodule

@@ src/ssrp_engine.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ssrp_engine (
  input  logic            clk,
  input  logic            rst,
  input  ssrp_pkg::flow_t flow,
  input  ssrp_pkg::item_t item,
  input  logic [7:0]      switch_bank_one,
  input  logic [7:0]      switch_bank_two,
  output logic [3:0]      result
);
  import ssrp_pkg::*;

  logic        held_in_reset;
  logic [4:0]  bit_position;
  logic [8:0]  command_bits;
  logic        data_line;
  logic        clock_line;
  logic        read_line;
  logic [15:0] reply_word;

  logic        held_in_reset_next;
  logic [4:0]  bit_position_next;
  logic [8:0]  command_bits_next;
  logic        data_line_next;
  logic        clock_line_next;
  logic        read_line_next;
  logic [15:0] reply_word_next;

  logic        fire;
  logic [8:0]  shifted_cmd;

  assign fire = flow.advance;

  always_comb begin
    held_in_reset_next = held_in_reset;
    bit_position_next  = bit_position;
    command_bits_next  = command_bits;
    data_line_next     = data_line;
    clock_line_next    = clock_line;
    read_line_next     = read_line;
    reply_word_next    = reply_word;
    shifted_cmd        = command_bits | ({8'd0, data_line} << bit_position[3:0]);
    if (item.func == FUNC_WRITE) begin
      case (item.code)
        CODE_RESET_ON: begin
          held_in_reset_next = 1'b1;
        end
        CODE_RESET_OFF: begin
          held_in_reset_next = 1'b0;
          bit_position_next  = 5'd0;
          command_bits_next  = 9'd0;
          data_line_next     = 1'b0;
          read_line_next     = 1'b0;
          clock_line_next    = 1'b1;
        end
        CODE_DATA_SET: begin
          data_line_next = 1'b1;
        end
        CODE_DATA_CLR: begin
          data_line_next = 1'b0;
        end
        CODE_CLK_HIGH: begin
          clock_line_next = 1'b1;
        end
        CODE_CLK_LOW: begin
          if (clock_line) begin
            if (bit_position < POS_CMD_END) begin
              command_bits_next = shifted_cmd;
            end
            if (bit_position == POS_DECODE) begin
              case (shifted_cmd)
                CMD_STATUS:   reply_word_next = {STATUS_HIGH_BYTE, item.status};
                CMD_BANK_ONE: reply_word_next = {switch_bank_one, item.status};
                CMD_BANK_TWO: reply_word_next = {switch_bank_two, item.status};
                default:      reply_word_next = reply_word;
              endcase
            end
            if (bit_position < POS_REPLY_END) begin
              read_line_next = reply_word_next[bit_position[3:0]];
            end else begin
              read_line_next = 1'b0;
            end
            if (bit_position != POS_LAST) begin
              bit_position_next = bit_position + 5'd1;
            end
            clock_line_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_in_reset <= 1'b0;
      bit_position  <= 5'd0;
      command_bits  <= 9'd0;
      data_line     <= 1'b0;
      clock_line    <= 1'b0;
      read_line     <= 1'b0;
      reply_word    <= 16'd0;
    end else if (fire) begin
      held_in_reset <= held_in_reset_next;
      bit_position  <= bit_position_next;
      command_bits  <= command_bits_next;
      data_line     <= data_line_next;
      clock_line    <= clock_line_next;
      read_line     <= read_line_next;
      reply_word    <= reply_word_next;
    end
  end

  assign result = (item.func == FUNC_READ) ? {clock_line, 1'b0, read_line, 1'b0} : 4'd0;

  `SSRP_ASSERT(a_pos_holds_when_idle, clk, rst, !fire |=> $stable(bit_position), "bit position moved without a beat")
  `SSRP_ASSERT(a_reset_code_recorded, clk, rst, fire && item.func == FUNC_WRITE && item.code == CODE_RESET_ON |=> held_in_reset, "reset request not recorded")
  `SSRP_ASSERT_ALWAYS(a_read_low_at_start, clk, bit_position == 5'd0 |-> !read_line, "read line high before any shift")

endmodule

@@ src/ssrp_out_stage.sv @@
`timescale 1ns / 1ps
module ssrp_out_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic [3:0] result,
  output logic       advance,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] read_data
);

  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      read_data <= result;
    end
  end

endmodule

@@ src/serial_switch_reader_port_top.sv @@
`timescale 1ns / 1ps
// A result is valid once its item has passed the input register and then the result register.
// Throughput: one item per cycle while not stalled; a beat is one decode-logic state update.
// A stalled result holds the result register and, once the input register is full, the input.
// Reset (rst, synchronous, active high) clears all line, shifter and reply state and
// loads switch bank one with 155 and bank two with 240.
module serial_switch_reader_port_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       func,
  input  logic [7:0] write_data,
  input  logic [7:0] status_switches,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] read_data,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import ssrp_pkg::*;

  item_t      in_item;
  item_t      item;
  flow_t      flow;
  logic       advance;
  logic [3:0] result;
  logic [7:0] switch_bank_one;
  logic [7:0] switch_bank_two;

  assign in_item.func   = func;
  assign in_item.code   = write_data[3:0];
  assign in_item.status = status_switches;

  always_ff @(posedge clk) begin
    if (rst) begin
      switch_bank_one <= BANK_ONE_RESET;
      switch_bank_two <= BANK_TWO_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BANK_ONE: switch_bank_one <= cfg_data;
        CFG_BANK_TWO: switch_bank_two <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ssrp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .flow     (flow),
    .item     (item)
  );

  ssrp_engine u_engine (
    .clk             (clk),
    .rst             (rst),
    .flow            (flow),
    .item            (item),
    .switch_bank_one (switch_bank_one),
    .switch_bank_two (switch_bank_two),
    .result          (result)
  );

  ssrp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (flow.valid),
    .result    (result),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_data (read_data)
  );

endmodule
